// File: design/phdp_pkg.sv
// ----------------------------------------------------------------------------
// Point height/depth projector package
// Shared widths and register indexes.
// ----------------------------------------------------------------------------
package phdp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int VEC_WIDTH   = 16;
  localparam int AXES        = 3;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X       = 3'd0,
    REG_FOCAL_Y       = 3'd1,
    REG_FOCAL_Z       = 3'd2,
    REG_UP_X          = 3'd3,
    REG_UP_Y          = 3'd4,
    REG_UP_Z          = 3'd5,
    REG_CAMERA_HEIGHT = 3'd6
  } cfg_reg_t;

endpackage

// File: design/phdp_point_if.sv
// ----------------------------------------------------------------------------
// Point channel
// One beat carries one signed point in the camera frame.
// ----------------------------------------------------------------------------
interface phdp_point_if #(
  parameter int COORD_WIDTH = phdp_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: design/phdp_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// One beat carries depth, height and the behind-camera flag of one point.
// ----------------------------------------------------------------------------
interface phdp_result_if #(
  parameter int COORD_WIDTH = phdp_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH-2:0] depth;
  logic signed [COORD_WIDTH-1:0] height;
  logic                          behind_camera;

  modport source (output valid, depth, height, behind_camera, input ready);
  modport sink   (input valid, depth, height, behind_camera, output ready);
endinterface

// File: design/phdp_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface phdp_cfg_if #(
  parameter int DATA_W = phdp_pkg::COORD_WIDTH - 1
);
  logic                             valid;
  logic                             ready;
  logic [phdp_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_W-1:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/phdp_pipe.sv
// ----------------------------------------------------------------------------
// Projection pipeline
// Six register stages: focal products, depth sum, depth-focal products,
// plane projection, up products, height sum with saturation.
// ----------------------------------------------------------------------------
module phdp_pipe #(
  parameter int COORD_WIDTH = phdp_pkg::COORD_WIDTH,
  parameter int VEC_WIDTH   = phdp_pkg::VEC_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point [phdp_pkg::AXES],
  input  logic signed [VEC_WIDTH-1:0]   focal [phdp_pkg::AXES],
  input  logic signed [VEC_WIDTH-1:0]   up    [phdp_pkg::AXES],
  input  logic        [COORD_WIDTH-2:0] cam_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [COORD_WIDTH-2:0] depth,
  output logic signed [COORD_WIDTH-1:0] height,
  output logic                          behind_camera
);

  localparam int N   = phdp_pkg::AXES;
  localparam int NST = 6;
  localparam int C   = COORD_WIDTH;
  localparam int S   = VEC_WIDTH - 1;
  localparam int PW  = C + VEC_WIDTH;
  localparam int DSW = PW + 2;
  localparam int DW  = DSW - S;
  localparam int MW  = DW + VEC_WIDTH;
  localparam int TW  = MW - S;
  localparam int QW  = TW + 1;
  localparam int UPW = QW + VEC_WIDTH;
  localparam int USW = UPW + 2;
  localparam int HSW = USW - S;
  localparam int HW  = HSW + 1;

  logic [NST:1]   v_r;
  logic [NST:1]   v_nxt;
  logic [NST+1:1] rdy;

  always_comb begin
    rdy[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[1] = rdy[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];

  // stage 1: focal products
  logic signed [PW-1:0] pf1_r [N];
  logic signed [C-1:0]  p1_r  [N];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < N; i++) begin
        pf1_r[i] <= PW'(focal[i]) * PW'(point[i]);
        p1_r[i]  <= point[i];
      end
    end
  end

  // stage 2: depth sum
  logic signed [DSW-1:0] dsum;
  logic signed [DW-1:0]  d2_r;
  logic                  b2_r;
  logic signed [C-1:0]   p2_r [N];

  assign dsum = DSW'(pf1_r[0]) + DSW'(pf1_r[1]) + DSW'(pf1_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      d2_r <= dsum[DSW-1:S];
      b2_r <= dsum[DSW-1] || (dsum == '0);
      p2_r <= p1_r;
    end
  end

  // stage 3: depth times focal, saturate depth
  logic signed [MW-1:0] m3_r [N];
  logic signed [C-1:0]  p3_r [N];
  logic        [C-2:0]  dsat3;
  logic        [C-2:0]  d3_r;
  logic                 b3_r;

  always_comb begin
    if (b2_r || (|d2_r[DW-1:C-1])) begin
      dsat3 = '1;
    end else begin
      dsat3 = d2_r[C-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < N; i++) begin
        m3_r[i] <= MW'(d2_r) * MW'(focal[i]);
      end
      p3_r <= p2_r;
      d3_r <= dsat3;
      b3_r <= b2_r;
    end
  end

  // stage 4: project onto plane
  logic signed [TW-1:0] t4   [N];
  logic signed [QW-1:0] q4_r [N];
  logic        [C-2:0]  d4_r;
  logic                 b4_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      t4[i] = m3_r[i][MW-1:S];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < N; i++) begin
        q4_r[i] <= QW'(p3_r[i]) - QW'(t4[i]);
      end
      d4_r <= d3_r;
      b4_r <= b3_r;
    end
  end

  // stage 5: up products
  logic signed [UPW-1:0] uq5_r [N];
  logic        [C-2:0]   d5_r;
  logic                  b5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < N; i++) begin
        uq5_r[i] <= UPW'(up[i]) * UPW'(q4_r[i]);
      end
      d5_r <= d4_r;
      b5_r <= b4_r;
    end
  end

  // stage 6: height sum, offset, saturate
  logic signed [USW-1:0] usum;
  logic signed [HSW-1:0] hs;
  logic signed [HW-1:0]  hraw;
  logic signed [C-1:0]   hsat;
  logic        [C-2:0]   depth_r;
  logic signed [C-1:0]   height_r;
  logic                  behind_r;

  always_comb begin
    usum = USW'(uq5_r[0]) + USW'(uq5_r[1]) + USW'(uq5_r[2]);
    hs   = usum[USW-1:S];
    hraw = HW'(hs) + HW'($signed({1'b0, cam_height}));
    if (b5_r) begin
      hsat = '0;
    end else if ((&hraw[HW-1:C-1]) || !(|hraw[HW-1:C-1])) begin
      hsat = hraw[C-1:0];
    end else if (hraw[HW-1]) begin
      hsat = {1'b1, {(C-1){1'b0}}};
    end else begin
      hsat = {1'b0, {(C-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      depth_r  <= d5_r;
      height_r <= hsat;
      behind_r <= b5_r;
    end
  end

  assign depth         = depth_r;
  assign height        = height_r;
  assign behind_camera = behind_r;

endmodule

// File: design/point_height_depth_projector.sv
// ----------------------------------------------------------------------------
// Point height/depth projector
// Depth along the focal vector and height along the up vector of each point.
// ----------------------------------------------------------------------------
//  channel     dir  beat contents
//  in_point    in   point_x, point_y, point_z
//  out_result  out  depth, height, behind_camera
//  cfg_wr      in   index, data (focal, up, camera height)
//
//  One point enters per cycle while the output is not stalled, through the
//  six-stage multiply/sum pipeline.
//  Each full stage holds while the stage after it is full and not moving, so a
//  stalled output fills the pipeline before in_point.ready drops.
//  Reset clears all stage valid bits and loads the default vectors.
//  Configuration beats are always taken.
// ----------------------------------------------------------------------------
module point_height_depth_projector #(
  parameter int COORD_WIDTH = phdp_pkg::COORD_WIDTH,
  parameter int VEC_WIDTH   = phdp_pkg::VEC_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  phdp_point_if.sink    in_point,
  phdp_result_if.source out_result,
  phdp_cfg_if.sink      cfg_wr
);

  localparam int N = phdp_pkg::AXES;

  logic signed [VEC_WIDTH-1:0]   focal_r [N];
  logic signed [VEC_WIDTH-1:0]   up_r    [N];
  logic        [COORD_WIDTH-2:0] cam_r;
  logic signed [COORD_WIDTH-1:0] point   [N];

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r[0] <= '0;
      focal_r[1] <= '0;
      focal_r[2] <= {1'b0, {(VEC_WIDTH-1){1'b1}}};
      up_r[0]    <= '0;
      up_r[1]    <= {1'b0, {(VEC_WIDTH-1){1'b1}}};
      up_r[2]    <= '0;
      cam_r      <= '0;
    end else if (cfg_wr.valid) begin
      unique case (phdp_pkg::cfg_reg_t'(cfg_wr.index))
        phdp_pkg::REG_FOCAL_X:       focal_r[0] <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_FOCAL_Y:       focal_r[1] <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_FOCAL_Z:       focal_r[2] <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_UP_X:          up_r[0]    <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_UP_Y:          up_r[1]    <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_UP_Z:          up_r[2]    <= cfg_wr.data[VEC_WIDTH-1:0];
        phdp_pkg::REG_CAMERA_HEIGHT: cam_r      <= cfg_wr.data[COORD_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  assign point[0] = in_point.point_x;
  assign point[1] = in_point.point_y;
  assign point[2] = in_point.point_z;

  phdp_pipe #(
    .COORD_WIDTH (COORD_WIDTH),
    .VEC_WIDTH   (VEC_WIDTH)
  ) u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_point.valid),
    .in_ready      (in_point.ready),
    .point         (point),
    .focal         (focal_r),
    .up            (up_r),
    .cam_height    (cam_r),
    .out_valid     (out_result.valid),
    .out_ready     (out_result.ready),
    .depth         (out_result.depth),
    .height        (out_result.height),
    .behind_camera (out_result.behind_camera)
  );

`ifndef SYNTHESIS
  a_behind_forces_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && out_result.behind_camera |->
      (out_result.height == '0) && (&out_result.depth))
    else $error("behind-camera beat without forced depth and height");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_point.ready |-> out_result.valid && !out_result.ready)
    else $error("input held off while output is free");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_result.valid)
    else $error("result beat straight after reset");
`endif

endmodule
